/* rtl/core/n2a_pkg.sv */
// n2a_pkg: types, constants and helpers shared by the number-to-ascii formatter.
// Used by every module of the block; depends on nothing else.

package n2a_pkg;

   // field widths
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned DIG_W      = 4;
   localparam int unsigned NUM_DIGITS = 16;
   localparam int unsigned NDIG_W     = 5;
   localparam int unsigned BCD_DIGITS = 10;
   localparam int unsigned BCD_W      = BCD_DIGITS * DIG_W;
   localparam int unsigned HEX_DIGITS = 8;
   localparam int unsigned OCT_DIGITS = 11;
   localparam int unsigned BIN_DIGITS = 16;

   // default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // ascii codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_A     = 8'd65;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] ASCII_X     = 8'd120;

   // output format selector
   typedef enum logic [1:0] {
      FMT_DEC = 2'd0,
      FMT_HEX = 2'd1,
      FMT_OCT = 2'd2,
      FMT_BIN = 2'd3
   } fmt_type;

   // classified request as it travels from front to back
   typedef struct packed {
      fmt_type              fmt;
      logic                 neg;
      logic [VALUE_W-1:0]   mag;
   } entry_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CONV,
      BK_SKIP,
      BK_PFX,
      BK_EMIT
   } back_state_type;

   // ascii code of one digit, 0-9 then upper-case A-F
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {{(CHAR_W-DIG_W){1'b0}}, d};
      if (d > 4'd9) begin
         digit_char = ASCII_A + dx - 8'd10;
      end else begin
         digit_char = ASCII_ZERO + dx;
      end
   endfunction

endpackage

/* rtl/core/n2a_front.sv */
// n2a_front: accepts requests and classifies them (format, sign, magnitude).
// Depends on n2a_pkg.

module n2a_front import n2a_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [VALUE_W-1:0] req_value,
   output logic               push_valid,
   input  logic               push_ready,
   output entry_type          push_data
);

   logic      stg_valid_ff, stg_valid_in;
   entry_type stg_ff, stg_in;
   logic      accept;
   fmt_type   fmt;
   logic      neg;

   // stage takes a request when empty or when its entry moves on
   assign req_ready  = ~stg_valid_ff | push_ready;
   assign accept     = req_valid & req_ready;
   assign push_valid = stg_valid_ff;
   assign push_data  = stg_ff;

   // classify: decimal negatives carry their magnitude, formed unsigned
   always_comb begin
      fmt        = fmt_type'(req_cmd);
      neg        = (fmt == FMT_DEC) & req_value[VALUE_W-1];
      stg_in     = stg_ff;
      stg_in.fmt = fmt;
      stg_in.neg = neg;
      stg_in.mag = neg ? (32'd0 - req_value) : req_value;
   end

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (push_ready) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= stg_in;
      end
   end

endmodule

/* rtl/core/n2a_queue.sv */
// n2a_queue: short request queue between front and back, with a registered head.
// Depends on n2a_pkg.

module n2a_queue import n2a_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop,
   output entry_type pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             head_valid_ff, head_valid_in;
   entry_type        head_ff;
   logic             do_wr, do_rd;

   assign push_ready = (cnt_ff != CNT_FULL);
   assign do_wr      = push_valid & push_ready;
   assign do_rd      = (cnt_ff != '0) & (~head_valid_ff | pop);
   assign pop_valid  = head_valid_ff;
   assign pop_data   = head_ff;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr & ~do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd & ~do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // head register refills from storage
   always_comb begin
      head_valid_in = head_valid_ff;
      if (do_rd) begin
         head_valid_in = 1'b1;
      end else if (pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         cnt_ff        <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         cnt_ff        <= cnt_in;
         head_valid_ff <= head_valid_in;
      end
   end

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (do_rd) begin
         head_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

/* rtl/core/n2a_bcd.sv */
// n2a_bcd: iterative binary to bcd converter, shift-and-add-3, two bits a cycle.
// Depends on n2a_pkg.

module n2a_bcd import n2a_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] mag,
   output logic               done,
   output logic [BCD_W-1:0]   bcd
);

   localparam int unsigned STEPS = VALUE_W / 2;
   localparam int unsigned CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [VALUE_W-1:0] m;
   logic [BCD_W-1:0]   b;

   assign done = done_ff;
   assign bcd  = bcd_ff;

   // two shift-and-correct steps on the bcd digits
   always_comb begin
      b = bcd_ff;
      m = mag_ff;
      for (int s = 0; s < 2; s++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (b[d*DIG_W +: DIG_W] >= 4'd5) begin
               b[d*DIG_W +: DIG_W] = b[d*DIG_W +: DIG_W] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], m[VALUE_W-1]};
         m = {m[VALUE_W-2:0], 1'b0};
      end
   end

   // iteration control
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         mag_in = mag;
         bcd_in = '0;
      end else if (run_ff) begin
         mag_in = m;
         bcd_in = b;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

endmodule

/* rtl/core/n2a_back.sv */
// n2a_back: takes classified requests from the queue and emits their characters.
// Depends on n2a_pkg and n2a_bcd.

module n2a_back import n2a_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop,
   input  entry_type         pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_char_code,
   output logic              rsp_last
);

   localparam logic [NDIG_W-1:0] NDIG_ONE = NDIG_W'(1);

   back_state_type state_ff, state_in;
   logic [NUM_DIGITS-1:0][DIG_W-1:0] dig_ff, dig_in;
   logic [NDIG_W-1:0] ndig_ff, ndig_in;
   logic              skip_ff, skip_in;
   logic [1:0]        pfx_ff, pfx_in;
   logic              hex_ff, hex_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;
   logic              bcd_start;
   logic              bcd_done;
   logic [BCD_W-1:0]  bcd;
   logic              top_zero;
   logic [VALUE_W:0]  oct_word;

   assign out_free      = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign pop           = pop_valid & (state_ff == BK_IDLE);
   assign bcd_start     = pop & (pop_data.fmt == FMT_DEC);
   assign top_zero      = (dig_ff[NUM_DIGITS-1] == '0);
   assign oct_word      = {1'b0, pop_data.mag};

   n2a_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .mag   (pop_data.mag),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               state_in = (pop_data.fmt == FMT_DEC) ? BK_CONV : BK_SKIP;
            end
         end
         BK_CONV: begin
            if (bcd_done) begin
               state_in = BK_SKIP;
            end
         end
         BK_SKIP: begin
            if (~skip_ff | (ndig_ff == NDIG_ONE) | ~top_zero) begin
               state_in = (pfx_ff != 2'd0) ? BK_PFX : BK_EMIT;
            end
         end
         BK_PFX: begin
            if (out_free & (pfx_ff == 2'd1)) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free & (ndig_ff == NDIG_ONE)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // digit store, prefix count and output register
   always_comb begin
      dig_in       = dig_ff;
      ndig_in      = ndig_ff;
      skip_in      = skip_ff;
      pfx_in       = pfx_ff;
      hex_in       = hex_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               skip_in = 1'b1;
               hex_in  = 1'b0;
               pfx_in  = 2'd0;
               unique case (pop_data.fmt)
                  FMT_DEC: begin
                     pfx_in = pop_data.neg ? 2'd1 : 2'd0;
                  end
                  FMT_HEX: begin
                     dig_in  = {pop_data.mag, {(NUM_DIGITS*DIG_W-VALUE_W){1'b0}}};
                     ndig_in = NDIG_W'(HEX_DIGITS);
                     pfx_in  = 2'd2;
                     hex_in  = 1'b1;
                  end
                  FMT_OCT: begin
                     dig_in = '0;
                     for (int i = 0; i < OCT_DIGITS; i++) begin
                        dig_in[NUM_DIGITS-1-i] = {1'b0, oct_word[VALUE_W-3*i -: 3]};
                     end
                     ndig_in = NDIG_W'(OCT_DIGITS);
                  end
                  FMT_BIN: begin
                     for (int i = 0; i < BIN_DIGITS; i++) begin
                        dig_in[i] = {3'b000, pop_data.mag[i]};
                     end
                     ndig_in = NDIG_W'(BIN_DIGITS);
                     skip_in = 1'b0;
                  end
                  default: ndig_in = NDIG_ONE;
               endcase
            end
         end
         BK_CONV: begin
            if (bcd_done) begin
               dig_in  = {bcd, {(NUM_DIGITS*DIG_W-BCD_W){1'b0}}};
               ndig_in = NDIG_W'(BCD_DIGITS);
            end
         end
         BK_SKIP: begin
            // drop one leading zero digit a cycle, keep at least one
            if (skip_ff & (ndig_ff != NDIG_ONE) & top_zero) begin
               dig_in  = {dig_ff[NUM_DIGITS-2:0], {DIG_W{1'b0}}};
               ndig_in = ndig_ff - 1'b1;
            end
         end
         BK_PFX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               if (hex_ff) begin
                  rsp_char_in = (pfx_ff == 2'd2) ? ASCII_ZERO : ASCII_X;
               end else begin
                  rsp_char_in = ASCII_MINUS;
               end
               pfx_in = pfx_ff - 1'b1;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(dig_ff[NUM_DIGITS-1]);
               rsp_last_in  = (ndig_ff == NDIG_ONE);
               dig_in       = {dig_ff[NUM_DIGITS-2:0], {DIG_W{1'b0}}};
               ndig_in      = ndig_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         ndig_ff      <= '0;
         pfx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ndig_ff      <= ndig_in;
         pfx_ff       <= pfx_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      skip_ff     <= skip_in;
      hex_ff      <= hex_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

/* rtl/core/number_to_ascii_formatter.sv */
// number_to_ascii_formatter: top level of the number to ascii formatter.
// Depends on n2a_pkg, n2a_front, n2a_queue and n2a_back.
//
// A request (req_cmd, req_value) selects signed decimal, hex with a 0x prefix,
// octal or 16-bit binary. The response channel carries one ascii character per
// response, most significant first, with rsp_last set on the final one.
// The front stage classifies a request into its register and hands it through a
// short queue (QUEUE_DEPTH entries plus a head register) to the back end,
// so new requests are taken while the back end is busy or stalled.
// Before its first character a request passes the front stage, queue storage,
// head register, the back end states BK_IDLE and BK_SKIP (which drops leading
// zeros) and the output register; decimal first waits in BK_CONV for the bcd
// converter, which handles two magnitude bits per cycle. The back end takes
// the next number only in BK_IDLE, after the last character of the current one;
// the back end sequencer sets the pace. A stalled rsp_ready holds the current
// character in the output register and holds the back end in its prefix and
// emit states; the queue keeps filling until it backs up to req_ready.
// Synchronous reset empties the front stage, queue and output.

module number_to_ascii_formatter import n2a_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_char_code,
   output logic               rsp_last
);

   logic      push_valid, push_ready;
   entry_type push_data;
   logic      pop_valid, pop;
   entry_type pop_data;

   // request classification
   n2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decoupling queue
   n2a_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   // conversion and character output
   n2a_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop           (pop),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

/* bench/tb_number_to_ascii_formatter.sv */
// tb_number_to_ascii_formatter: self-checking bench for the number to ascii formatter.
// Depends on n2a_pkg and number_to_ascii_formatter; drives requests, checks every
// character against table text or a built-in model, with random stalls on both sides.

module tb_number_to_ascii_formatter;
   import n2a_pkg::*;

   // one expected character of a printed number
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_exp_type;

   localparam int unsigned RANDOM_REQUESTS = 236;
   localparam int unsigned DRAIN_CYCLES    = 40;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_cmd;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [CHAR_W-1:0]  rsp_char_code;
   logic               rsp_last;

   char_exp_type char_q[$];
   int unsigned errors;
   int unsigned numbers_sent;
   int unsigned chars_checked;
   int unsigned numbers_done;
   bit quiet;

   // directed stimulus table; an empty text means the model decides
   fmt_type            row_fmt[$];
   logic [VALUE_W-1:0] row_value[$];
   string              row_text[$];

   number_to_ascii_formatter i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last     (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // expected characters for one number, most significant first
   function automatic int format_number(input fmt_type fmt, input logic [VALUE_W-1:0] value,
                                        output logic [CHAR_W-1:0] chars [16]);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] radix;
      logic [VALUE_W-1:0] d;
      logic [CHAR_W-1:0]  digits [32];
      int nd;
      int n;
      nd = 0;
      n = 0;
      for (int i = 0; i < 16; i++) chars[i] = '0;
      if (fmt == FMT_BIN) begin
         for (int k = 15; k >= 0; k--) begin
            chars[n] = value[k] ? ASCII_ZERO + 8'd1 : ASCII_ZERO;
            n = n + 1;
         end
      end else begin
         mag = value;
         if (fmt == FMT_DEC && value[31]) begin
            chars[n] = ASCII_MINUS;
            n = n + 1;
            mag = -value;
         end
         if (fmt == FMT_HEX) begin
            chars[n] = ASCII_ZERO;
            chars[n+1] = ASCII_X;
            n = n + 2;
         end
         case (fmt)
            FMT_DEC: radix = 32'd10;
            FMT_HEX: radix = 32'd16;
            default: radix = 32'd8;
         endcase
         // digits come out least significant first
         do begin
            d = mag % radix;
            digits[nd] = (d > 32'd9) ? ASCII_A + 8'(d - 32'd10) : ASCII_ZERO + 8'(d);
            nd = nd + 1;
            mag = mag / radix;
         end while (mag != 0);
         while (nd > 0 && n < 16) begin
            nd = nd - 1;
            chars[n] = digits[nd];
            n = n + 1;
         end
      end
      return n;
   endfunction

   // queue the characters of an accepted request
   task automatic queue_number(input fmt_type fmt, input logic [VALUE_W-1:0] value,
                               input string text);
      logic [CHAR_W-1:0] chars [16];
      int n;
      char_exp_type e;
      if (text.len() > 0) begin
         for (int i = 0; i < text.len(); i++) begin
            e.code = text[i];
            e.last = (i == text.len() - 1);
            char_q.push_back(e);
         end
      end else begin
         n = format_number(fmt, value, chars);
         for (int i = 0; i < n; i++) begin
            e.code = chars[i];
            e.last = (i == n - 1);
            char_q.push_back(e);
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      errors = errors + 1;
      if (errors <= 50) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present one request and wait for it to be taken
   task automatic send_request(input fmt_type fmt, input logic [VALUE_W-1:0] value,
                               input string text);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= fmt;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      queue_number(fmt, value, text);
      numbers_sent = numbers_sent + 1;
   endtask

   // hold off new requests until every character has come back
   task automatic wait_all_chars();
      @(negedge clock);
      req_valid <= 1'b0;
      while (char_q.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input fmt_type fmt, input logic [VALUE_W-1:0] value, input string text);
      row_fmt.push_back(fmt);
      row_value.push_back(value);
      row_text.push_back(text);
   endtask

   // random value with a bias toward digit-count boundaries and the sign edge
   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      int k;
      r = $urandom_range(0, 9);
      k = $urandom_range(0, 31);
      case (r)
         4: return $urandom_range(0, 20);
         5: return (32'd1 << k);
         6: return (32'd1 << k) - 32'd1;
         7: return 32'h8000_0000 + $urandom_range(0, 15);
         8: return {16'h0, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // request side: reset, directed table, then random numbers
   initial begin
      fmt_type fmt;
      req_valid = 1'b0;
      req_cmd   = FMT_DEC;
      req_value = '0;
      reset     = 1'b1;
      errors = 0;
      numbers_sent = 0;
      chars_checked = 0;
      numbers_done = 0;
      quiet = 1'b0;

      add_row(FMT_DEC, 32'd0,          "0");
      add_row(FMT_DEC, 32'd9,          "9");
      add_row(FMT_DEC, 32'd10,         "10");
      add_row(FMT_DEC, 32'h7FFF_FFFF,  "2147483647");
      add_row(FMT_DEC, 32'h8000_0000,  "-2147483648");
      add_row(FMT_DEC, 32'hFFFF_FFFF,  "-1");
      add_row(FMT_DEC, 32'd1000000000, "");
      add_row(FMT_DEC, 32'hC465_3600,  "");
      add_row(FMT_HEX, 32'd0,          "0x0");
      add_row(FMT_HEX, 32'd10,         "0xA");
      add_row(FMT_HEX, 32'hFFFF_FFFF,  "0xFFFFFFFF");
      add_row(FMT_HEX, 32'h1000_0000,  "0x10000000");
      add_row(FMT_HEX, 32'h0123_4567,  "");
      add_row(FMT_HEX, 32'hDEAD_BEEF,  "0xDEADBEEF");
      add_row(FMT_OCT, 32'd0,          "0");
      add_row(FMT_OCT, 32'd7,          "7");
      add_row(FMT_OCT, 32'd8,          "10");
      add_row(FMT_OCT, 32'hFFFF_FFFF,  "37777777777");
      add_row(FMT_OCT, 32'h4000_0000,  "");
      add_row(FMT_BIN, 32'd0,          "0000000000000000");
      add_row(FMT_BIN, 32'hFFFF_FFFF,  "1111111111111111");
      add_row(FMT_BIN, 32'hFFFF_0000,  "0000000000000000");
      add_row(FMT_BIN, 32'h0000_8001,  "1000000000000001");
      add_row(FMT_BIN, 32'h5A5A_A5C3,  "");

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      for (int i = 0; i < row_fmt.size(); i++) begin
         send_request(row_fmt[i], row_value[i], row_text[i]);
      end
      wait_all_chars();

      // random part, with a stall-free stretch and two full drains
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         quiet = (i >= 120 && i < 160);
         if (i == 60 || i == 200) wait_all_chars();
         fmt = fmt_type'($urandom_range(0, 3));
         send_request(fmt, pick_value(), "");
      end
      quiet = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // drain and let any stray character show up
      while (char_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d numbers (%0d from the table) in all four formats", numbers_sent,
               row_fmt.size());
      $display("checked %0d characters ending %0d numbers, %0d mismatches", chars_checked,
               numbers_done, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // response side: random backpressure with long ready stretches
   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   end

   // check each accepted character against the oldest expectation
   always @(posedge clock) begin
      char_exp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (char_q.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                      rsp_char_code, rsp_last));
         end else begin
            e = char_q.pop_front();
            chars_checked = chars_checked + 1;
            if (e.last) numbers_done = numbers_done + 1;
            if (rsp_char_code !== e.code) begin
               report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                         rsp_char_code, e.code));
            end
            if (rsp_last !== e.last) begin
               report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                         rsp_last, e.last, e.code));
            end
         end
      end
   end

   // timeout
   initial begin
      #15_000_000;
      $display("timeout with %0d characters outstanding", char_q.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/n2a_pkg.sv
rtl/core/n2a_front.sv
rtl/core/n2a_queue.sv
rtl/core/n2a_bcd.sv
rtl/core/n2a_back.sv
rtl/core/number_to_ascii_formatter.sv
bench/tb_number_to_ascii_formatter.sv
